// File: hdl/kseq_pkg.sv
// Shared types, request codes and constants for the key state and event queue block.
package kseq_pkg;

   // Field widths of the request and response words
   localparam int REQ_TYPE_W = 3;
   localparam int KEY_IDX_W  = 7;
   localparam int CODE_W     = 21;

   // Character codes below this value are control characters and get dropped
   localparam logic [CODE_W-1:0] MIN_CHAR_CODE = 21'd32;

   // Request type codes as they arrive on the input word
   localparam logic [REQ_TYPE_W-1:0] REQ_KEY_EVENT  = 3'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_CHAR_EVENT = 3'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_FRAME_TICK = 3'd2;
   localparam logic [REQ_TYPE_W-1:0] REQ_KEY_QUERY  = 3'd3;
   localparam logic [REQ_TYPE_W-1:0] REQ_POP_KEY    = 3'd4;
   localparam logic [REQ_TYPE_W-1:0] REQ_POP_CHAR   = 3'd5;

   // Decoded operation handed from the controller to the datapath
   typedef enum logic [2:0] {
      OP_NONE,
      OP_KEY,
      OP_CHAR,
      OP_TICK,
      OP_QUERY,
      OP_POP_KEY,
      OP_POP_CHAR
   } kseq_op_type;

   // Output register occupancy
   typedef enum logic {
      ST_EMPTY,
      ST_FULL
   } kseq_state_type;

   typedef struct packed {
      logic                  exec;
      kseq_op_type           op;
   } kseq_cmd_type;

   typedef struct packed {
      logic [REQ_TYPE_W-1:0] req_type;
      logic [KEY_IDX_W-1:0]  key_index;
      logic                  key_is_down;
      logic                  key_is_repeat;
      logic [CODE_W-1:0]     char_code;
   } kseq_req_word_type;

   typedef struct packed {
      logic                  is_down;
      logic                  is_pressed;
      logic                  is_pressed_or_repeat;
      logic [CODE_W-1:0]     popped_value;
   } kseq_rsp_word_type;

endpackage

// File: hdl/key_state_edge_and_event_queue.sv
// Top level of the keyboard state latch with press and text event FIFOs.
//
// Requests arrive as one word on req_valid/req_stall/req_word: key events,
// character events, frame ticks, key queries and pops of either FIFO.
// Every request gives exactly one response word on rsp_valid/rsp_stall/
// rsp_word; fields that do not belong to the request read zero.
// The response sits in the output register on the cycle after the request
// is taken. Throughput is one word per cycle while rsp_stall is low, set
// by the single read-modify-write of the key vectors and FIFO pointers.
// While the receiver stalls, the held response stays put and req_stall
// follows rsp_stall; once it is taken a new word may enter in that cycle.
// Reset (synchronous) clears all three key vectors, empties both FIFOs and
// the output register. FIFO storage is not cleared; only pushed entries
// are ever read. A frame tick copies the held keys to the last-frame
// vector, clears the repeat bits and empties both FIFOs. Pushes into a
// full FIFO are dropped, and a pop of an empty FIFO returns zero.
module key_state_edge_and_event_queue #(
   parameter int NUM_KEYS   = 128,
   parameter int FIFO_DEPTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  kseq_pkg::kseq_req_word_type   req_word,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output kseq_pkg::kseq_rsp_word_type   rsp_word
);
   import kseq_pkg::*;

   kseq_cmd_type cmd;

   kseq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_word.req_type),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   kseq_dp #(
      .NUM_KEYS   (NUM_KEYS),
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_word (req_word),
      .rsp_word (rsp_word)
   );

endmodule

// File: hdl/kseq_fifo.sv
// Event FIFO: storage array, head pointer, fill count and registered pop read.
module kseq_fifo #(
   parameter int DATA_W = 21,
   parameter int DEPTH  = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  logic              push,
   input  logic              pop,
   input  logic              clear,
   input  logic [DATA_W-1:0] push_data,
   output logic [DATA_W-1:0] pop_value
);
   import kseq_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = PTR_W + 1;

   logic [DATA_W-1:0] mem [DEPTH];
   logic [PTR_W-1:0]  head_ff, head_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [SUM_W-1:0]  tail_sum;
   logic [PTR_W-1:0]  tail;
   logic              empty;
   logic              full;
   logic              do_push;
   logic [DATA_W-1:0] pop_value_ff;

   // Tail slot is head plus count, wrapped once
   always_comb begin
      tail_sum = SUM_W'(head_ff) + SUM_W'(count_ff);
      tail     = (tail_sum >= SUM_W'(DEPTH)) ? PTR_W'(tail_sum - SUM_W'(DEPTH))
                                             : PTR_W'(tail_sum);
      empty    = (count_ff == '0);
      full     = (count_ff == CNT_W'(DEPTH));
      do_push  = push && !full && !clear;
   end

   // Pointer and count update; a push into a full FIFO is dropped
   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (clear) begin
         head_in  = '0;
         count_in = '0;
      end else if (do_push) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !empty) begin
         head_in  = (head_ff == PTR_W'(DEPTH - 1)) ? '0 : head_ff + PTR_W'(1);
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   // Storage write
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[tail] <= push_data;
      end
   end

   // Registered read of the oldest entry; zero when not popping or empty
   always_ff @(posedge clock) begin
      if (load) begin
         pop_value_ff <= (pop && !empty) ? mem[head_ff] : '0;
      end
   end

   assign pop_value = pop_value_ff;

endmodule

// File: hdl/kseq_dp.sv
// Datapath: key state vectors, the two event FIFOs and the response register.
module kseq_dp #(
   parameter int NUM_KEYS   = 128,
   parameter int FIFO_DEPTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  kseq_pkg::kseq_cmd_type        cmd,
   input  kseq_pkg::kseq_req_word_type   req_word,
   output kseq_pkg::kseq_rsp_word_type   rsp_word
);
   import kseq_pkg::*;

   localparam int KEY_W = $clog2(NUM_KEYS);

   logic [NUM_KEYS-1:0]  held_now_ff, held_now_in;
   logic [NUM_KEYS-1:0]  held_last_ff, held_last_in;
   logic [NUM_KEYS-1:0]  repeat_ff, repeat_in;
   logic                 key_ok;
   logic [KEY_W-1:0]     key_sel;
   logic                 q_down, q_pressed, q_por;
   logic                 press_push, text_push;
   logic                 pop_key, pop_char, tick;
   logic [KEY_IDX_W-1:0] press_value;
   logic [CODE_W-1:0]    text_value;
   logic                 is_down_ff, is_pressed_ff, is_por_ff;
   logic                 pop_key_ff, pop_char_ff;

   // Key number check and vector index
   always_comb begin
      key_ok  = (req_word.key_index != '0) && (32'(req_word.key_index) < NUM_KEYS);
      key_sel = KEY_W'(req_word.key_index);
   end

   // Decoded strobes for this word
   always_comb begin
      tick       = cmd.exec && (cmd.op == OP_TICK);
      pop_key    = cmd.exec && (cmd.op == OP_POP_KEY);
      pop_char   = cmd.exec && (cmd.op == OP_POP_CHAR);
      press_push = cmd.exec && (cmd.op == OP_KEY) && key_ok && req_word.key_is_down
                   && !held_now_ff[key_sel];
      text_push  = cmd.exec && (cmd.op == OP_CHAR) && (req_word.char_code >= MIN_CHAR_CODE);
   end

   // Key state vector update
   always_comb begin
      held_now_in  = held_now_ff;
      held_last_in = held_last_ff;
      repeat_in    = repeat_ff;
      if (cmd.exec) begin
         case (cmd.op)
            OP_KEY: begin
               if (key_ok) begin
                  if (req_word.key_is_down) begin
                     held_now_in[key_sel] = 1'b1;
                     if (req_word.key_is_repeat) begin
                        repeat_in[key_sel] = 1'b1;
                     end
                  end else begin
                     held_now_in[key_sel] = 1'b0;
                  end
               end
            end
            OP_TICK: begin
               held_last_in = held_now_ff;
               repeat_in    = '0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_now_ff  <= '0;
         held_last_ff <= '0;
         repeat_ff    <= '0;
      end else begin
         held_now_ff  <= held_now_in;
         held_last_ff <= held_last_in;
         repeat_ff    <= repeat_in;
      end
   end

   // Query lookup
   always_comb begin
      q_down    = key_ok && held_now_ff[key_sel];
      q_pressed = q_down && !held_last_ff[key_sel];
      q_por     = q_pressed || (key_ok && repeat_ff[key_sel]);
   end

   kseq_fifo #(
      .DATA_W (KEY_IDX_W),
      .DEPTH  (FIFO_DEPTH)
   ) u_press_fifo (
      .clock     (clock),
      .reset     (reset),
      .load      (cmd.exec),
      .push      (press_push),
      .pop       (pop_key),
      .clear     (tick),
      .push_data (req_word.key_index),
      .pop_value (press_value)
   );

   kseq_fifo #(
      .DATA_W (CODE_W),
      .DEPTH  (FIFO_DEPTH)
   ) u_text_fifo (
      .clock     (clock),
      .reset     (reset),
      .load      (cmd.exec),
      .push      (text_push),
      .pop       (pop_char),
      .clear     (tick),
      .push_data (req_word.char_code),
      .pop_value (text_value)
   );

   // Response register: query bits and pop source select
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         is_down_ff    <= (cmd.op == OP_QUERY) && q_down;
         is_pressed_ff <= (cmd.op == OP_QUERY) && q_pressed;
         is_por_ff     <= (cmd.op == OP_QUERY) && q_por;
         pop_key_ff    <= pop_key;
         pop_char_ff   <= pop_char;
      end
   end

   always_comb begin
      rsp_word.is_down              = is_down_ff;
      rsp_word.is_pressed           = is_pressed_ff;
      rsp_word.is_pressed_or_repeat = is_por_ff;
      if (pop_key_ff) begin
         rsp_word.popped_value = CODE_W'(press_value);
      end else if (pop_char_ff) begin
         rsp_word.popped_value = text_value;
      end else begin
         rsp_word.popped_value = '0;
      end
   end

endmodule

// File: hdl/kseq_ctrl.sv
// Controller: output register occupancy, handshake and request decode.
module kseq_ctrl (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic [kseq_pkg::REQ_TYPE_W-1:0]  req_type,
   output logic                             req_stall,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output kseq_pkg::kseq_cmd_type           cmd
);
   import kseq_pkg::*;

   kseq_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_EMPTY;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and handshake; a new word enters when the output slot frees up
   always_comb begin
      state_in  = state_ff;
      req_stall = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_EMPTY: begin
            if (req_valid) begin
               state_in = ST_FULL;
            end
         end
         ST_FULL: begin
            rsp_valid = 1'b1;
            req_stall = rsp_stall;
            if (!rsp_stall && !req_valid) begin
               state_in = ST_EMPTY;
            end
         end
         default: begin
            state_in = ST_EMPTY;
         end
      endcase
   end

   // Request decode
   always_comb begin
      cmd.exec = req_valid && !req_stall;
      case (req_type)
         REQ_KEY_EVENT:  cmd.op = OP_KEY;
         REQ_CHAR_EVENT: cmd.op = OP_CHAR;
         REQ_FRAME_TICK: cmd.op = OP_TICK;
         REQ_KEY_QUERY:  cmd.op = OP_QUERY;
         REQ_POP_KEY:    cmd.op = OP_POP_KEY;
         REQ_POP_CHAR:   cmd.op = OP_POP_CHAR;
         default:        cmd.op = OP_NONE;
      endcase
   end

endmodule

// File: dv/key_state_edge_and_event_queue_tb.sv
// Self-checking testbench for the key state latch with press and text event FIFOs.
`timescale 1ns / 100ps

module key_state_edge_and_event_queue_tb;
   import kseq_pkg::*;

   localparam int NUM_KEYS   = 128;
   localparam int FIFO_DEPTH = 16;
   localparam int WORD_GOAL  = 1650;
   localparam int STALL_LIMIT = 2000;
   localparam int LONG_HOLD  = 80;

   // request codes the block treats as no-ops
   localparam logic [REQ_TYPE_W-1:0] REQ_SPARE_A = 3'd6;
   localparam logic [REQ_TYPE_W-1:0] REQ_SPARE_B = 3'd7;

   logic              clock;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   kseq_req_word_type req_word = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   kseq_rsp_word_type rsp_word;

   key_state_edge_and_event_queue #(
      .NUM_KEYS   (NUM_KEYS),
      .FIFO_DEPTH (FIFO_DEPTH)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // words waiting to go out, and responses the key latch should give
   kseq_req_word_type request_q[$];
   kseq_rsp_word_type latch_answer_q[$];

   // shadow of the key vectors and the two event FIFOs
   logic [NUM_KEYS-1:0]  keys_held = '0;
   logic [NUM_KEYS-1:0]  keys_prev = '0;
   logic [NUM_KEYS-1:0]  keys_rep  = '0;
   logic [KEY_IDX_W-1:0] press_log[$];
   logic [CODE_W-1:0]    text_log[$];

   int   miss_count = 0;
   int   rsp_taken = 0;
   int   req_taken = 0;
   int   quiet_cycles = 0;
   int   kind_seen[8];
   int   press_drops = 0;
   int   text_drops = 0;
   logic req_took = 1'b0;

   int   send_gap = 0;
   int   stall_left = 0;
   int   hold_left = 0;
   logic hold_done = 1'b0;

   // apply one request to the shadow state and return the response it earns
   function automatic kseq_rsp_word_type key_latch_apply(input kseq_req_word_type w);
      kseq_rsp_word_type r;
      int                k;
      logic              key_ok;
      logic              fresh;
      r = '0;
      k = int'(w.key_index);
      key_ok = (k != 0) && (k < NUM_KEYS);
      case (w.req_type)
         REQ_KEY_EVENT: begin
            if (key_ok && w.key_is_down) begin
               // only an up-to-down change is queued
               if (!keys_held[k]) begin
                  if (press_log.size() < FIFO_DEPTH) press_log.push_back(w.key_index);
                  else press_drops++;
               end
               keys_held[k] = 1'b1;
               if (w.key_is_repeat) keys_rep[k] = 1'b1;
            end else if (key_ok) begin
               keys_held[k] = 1'b0;
            end
         end
         REQ_CHAR_EVENT: begin
            if (w.char_code >= MIN_CHAR_CODE) begin
               if (text_log.size() < FIFO_DEPTH) text_log.push_back(w.char_code);
               else text_drops++;
            end
         end
         REQ_FRAME_TICK: begin
            keys_prev = keys_held;
            keys_rep = '0;
            press_log.delete();
            text_log.delete();
         end
         REQ_KEY_QUERY: begin
            if (key_ok) begin
               fresh = keys_held[k] && !keys_prev[k];
               r.is_down = keys_held[k];
               r.is_pressed = fresh;
               r.is_pressed_or_repeat = fresh || keys_rep[k];
            end
         end
         REQ_POP_KEY: begin
            if (press_log.size() > 0) r.popped_value = CODE_W'(press_log.pop_front());
         end
         REQ_POP_CHAR: begin
            if (text_log.size() > 0) r.popped_value = text_log.pop_front();
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic queue_word(input logic [REQ_TYPE_W-1:0] kind, input int key,
                             input logic down, input logic rep, input int code);
      kseq_req_word_type w;
      w.req_type = kind;
      w.key_index = key[KEY_IDX_W-1:0];
      w.key_is_down = down;
      w.key_is_repeat = rep;
      w.char_code = code[CODE_W-1:0];
      request_q.push_back(w);
   endtask

   // keys mostly come from a small pool so presses, releases and repeats collide
   function automatic int pick_key();
      if ($urandom_range(0, 3) == 0) return $urandom_range(0, 127);
      return $urandom_range(1, 12);
   endfunction

   function automatic int pick_code();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 31);
         1: return $urandom_range(32, 126);
         2: return $urandom_range(0, 1114111);
         default: return $urandom & 32'h1F_FFFF;
      endcase
   endfunction

   // one frame of traffic: events, queries and pops, sometimes a flood, then a tick
   task automatic queue_frame();
      int len;
      int pick;
      int key;
      len = $urandom_range(3, 30);
      repeat (len) begin
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            queue_word(REQ_KEY_EVENT, pick_key(), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)), $urandom);
         end else if (pick < 55) begin
            queue_word(REQ_CHAR_EVENT, $urandom, 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)), pick_code());
         end else if (pick < 70) begin
            queue_word(REQ_KEY_QUERY, pick_key(), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)), $urandom);
         end else if (pick < 82) begin
            queue_word(REQ_POP_KEY, $urandom, 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)), $urandom);
         end else if (pick < 94) begin
            queue_word(REQ_POP_CHAR, $urandom, 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)), $urandom);
         end else begin
            // noise, unused codes included
            queue_word(REQ_TYPE_W'($urandom_range(0, 7)), $urandom,
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom);
         end
      end
      // overfill a FIFO now and then, then drain past empty
      case ($urandom_range(0, 5))
         0: begin
            repeat ($urandom_range(14, 20))
               queue_word(REQ_CHAR_EVENT, 0, 1'b0, 1'b0, $urandom_range(32, 1114111));
            repeat ($urandom_range(0, 20)) queue_word(REQ_POP_CHAR, 0, 1'b0, 1'b0, 0);
         end
         1: begin
            repeat ($urandom_range(14, 20)) begin
               key = $urandom_range(1, 127);
               queue_word(REQ_KEY_EVENT, key, 1'b1, 1'($urandom_range(0, 1)), 0);
               queue_word(REQ_KEY_EVENT, key, 1'b0, 1'b0, 0);
            end
            repeat ($urandom_range(0, 20)) queue_word(REQ_POP_KEY, 0, 1'b0, 1'b0, 0);
         end
         default: ;
      endcase
      queue_word(REQ_FRAME_TICK, $urandom, 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)), $urandom);
   endtask

   // request driver: a new word only after the last one was taken
   always @(negedge clock) begin : drive_req
      logic              nxt_valid;
      kseq_req_word_type nxt_word;
      logic              calm;
      nxt_valid = req_valid;
      nxt_word = req_word;
      calm = (request_q.size() < 120) || ((request_q.size() / 200) % 3 == 0);
      if (reset) begin
         nxt_valid = 1'b0;
      end else if (!req_valid || req_took) begin
         nxt_valid = 1'b0;
         if (send_gap > 0) begin
            send_gap--;
         end else if (request_q.size() > 0) begin
            if (!calm && $urandom_range(0, 9) == 0) begin
               send_gap = $urandom_range(0, 4);
            end else begin
               nxt_valid = 1'b1;
               nxt_word = request_q.pop_front();
            end
         end
      end
      req_valid <= nxt_valid;
      req_word <= nxt_word;
   end

   // response stall: short bursts, one long hold-off, none near the end
   always @(negedge clock) begin : drive_stall
      logic nxt_stall;
      logic calm;
      calm = (request_q.size() < 120) || ((rsp_taken / 150) % 3 == 0);
      nxt_stall = 1'b0;
      if (reset) begin
         nxt_stall = 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         nxt_stall = 1'b1;
      end else if (!hold_done && rsp_taken >= 400) begin
         hold_done = 1'b1;
         hold_left = LONG_HOLD - 1;
         nxt_stall = 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         nxt_stall = 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(0, 4);
         nxt_stall = 1'b1;
      end
      rsp_stall <= nxt_stall;
   end

   // monitor: check taken responses, predict from taken requests, watchdog
   always @(posedge clock) begin : watch_ports
      kseq_rsp_word_type want;
      logic              took_rsp;
      logic              took_req;
      if (reset) begin
         req_took <= 1'b0;
      end else begin
         took_rsp = rsp_valid && !rsp_stall;
         took_req = req_valid && !req_stall;
         req_took <= took_req;
         if (took_rsp) begin
            rsp_taken++;
            if (latch_answer_q.size() == 0) begin
               miss_count++;
               if (miss_count <= 10)
                  $display("%0t: response word with none pending: %p", $realtime, rsp_word);
            end else begin
               want = latch_answer_q.pop_front();
               if (rsp_word.is_down !== want.is_down ||
                   rsp_word.is_pressed !== want.is_pressed ||
                   rsp_word.is_pressed_or_repeat !== want.is_pressed_or_repeat ||
                   rsp_word.popped_value !== want.popped_value) begin
                  miss_count++;
                  if (miss_count <= 10)
                     $display("%0t: mismatch exp down=%b prs=%b por=%b val=%h",
                              $realtime, want.is_down, want.is_pressed,
                              want.is_pressed_or_repeat, want.popped_value,
                              " act down=%b prs=%b por=%b val=%h",
                              rsp_word.is_down, rsp_word.is_pressed,
                              rsp_word.is_pressed_or_repeat, rsp_word.popped_value);
               end
            end
         end
         if (took_req) begin
            req_taken++;
            kind_seen[req_word.req_type]++;
            latch_answer_q.push_back(key_latch_apply(req_word));
         end
         // nothing moving for too long means the block hung
         if (took_req || took_rsp) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $realtime, STALL_LIMIT);
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   initial begin
      foreach (kind_seen[i]) kind_seen[i] = 0;

      // directed: empty pops, invalid key, repeat rules, char edges, spare codes, tick
      queue_word(REQ_POP_KEY, 0, 1'b0, 1'b0, 0);
      queue_word(REQ_POP_CHAR, 0, 1'b0, 1'b0, 0);
      queue_word(REQ_KEY_EVENT, 0, 1'b1, 1'b1, 0);
      queue_word(REQ_KEY_QUERY, 0, 1'b0, 1'b0, 0);
      queue_word(REQ_KEY_EVENT, 127, 1'b1, 1'b1, 0);
      queue_word(REQ_KEY_EVENT, 1, 1'b1, 1'b0, 0);
      queue_word(REQ_KEY_QUERY, 127, 1'b0, 1'b0, 0);
      queue_word(REQ_KEY_QUERY, 1, 1'b0, 1'b0, 0);
      queue_word(REQ_KEY_EVENT, 1, 1'b0, 1'b1, 0);
      queue_word(REQ_KEY_QUERY, 1, 1'b0, 1'b0, 0);
      queue_word(REQ_CHAR_EVENT, 0, 1'b0, 1'b0, 31);
      queue_word(REQ_CHAR_EVENT, 0, 1'b0, 1'b0, 32);
      queue_word(REQ_CHAR_EVENT, 0, 1'b0, 1'b0, 32'h1F_FFFF);
      queue_word(REQ_CHAR_EVENT, 0, 1'b0, 1'b0, 1114111);
      repeat (4) queue_word(REQ_POP_CHAR, 0, 1'b0, 1'b0, 0);
      queue_word(REQ_POP_KEY, 0, 1'b0, 1'b0, 0);
      queue_word(REQ_SPARE_A, 127, 1'b1, 1'b1, 32'h1F_FFFF);
      queue_word(REQ_SPARE_B, 127, 1'b1, 1'b1, 32'h1F_FFFF);
      queue_word(REQ_FRAME_TICK, 0, 1'b0, 1'b0, 0);
      queue_word(REQ_KEY_QUERY, 127, 1'b0, 1'b0, 0);
      queue_word(REQ_KEY_EVENT, 127, 1'b1, 1'b1, 0);
      queue_word(REQ_KEY_QUERY, 127, 1'b0, 1'b0, 0);
      queue_word(REQ_POP_KEY, 0, 1'b0, 1'b0, 0);

      // random frames
      while (request_q.size() < WORD_GOAL) queue_frame();

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // drain stimulus, then all pending responses, then a few spare cycles
      while (request_q.size() > 0 || req_valid) @(negedge clock);
      while (latch_answer_q.size() > 0) @(negedge clock);
      repeat (8) @(negedge clock);

      $display("Ran %0d requests: %0d key events, %0d chars, %0d ticks, %0d queries,",
               req_taken, kind_seen[REQ_KEY_EVENT], kind_seen[REQ_CHAR_EVENT],
               kind_seen[REQ_FRAME_TICK], kind_seen[REQ_KEY_QUERY]);
      $display("  %0d key pops, %0d char pops; pushes dropped on full: %0d key, %0d char",
               kind_seen[REQ_POP_KEY], kind_seen[REQ_POP_CHAR], press_drops, text_drops);
      if (miss_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("%0d mismatches", miss_count);
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// File: sim.f
hdl/kseq_pkg.sv
hdl/kseq_fifo.sv
hdl/kseq_dp.sv
hdl/kseq_ctrl.sv
hdl/key_state_edge_and_event_queue.sv
dv/key_state_edge_and_event_queue_tb.sv
